// ===== rtl/core/sha256_pkg.sv =====
// Package: SHA-256 types, constants and round functions.
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic       opcode;
        logic [7:0] msg_byte;
    } s_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } m_item_t;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [60:0] LEN_MAX = {61{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    // Start of a compression and its completion, between sequencer and round unit.
    typedef struct packed {
        logic start;
        logic done;
    } round_ctl_t;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        case (i)
            3'd0: init_hash = 32'h6a09e667;
            3'd1: init_hash = 32'hbb67ae85;
            3'd2: init_hash = 32'h3c6ef372;
            3'd3: init_hash = 32'ha54ff53a;
            3'd4: init_hash = 32'h510e527f;
            3'd5: init_hash = 32'h9b05688c;
            3'd6: init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha256_stream_hasher.sv =====
// Top level: byte-stream SHA-256 hasher with digest word output.
`timescale 1ns / 1ps
`default_nettype none
// Streaming SHA-256. Send one transaction per message byte (opcode absorb),
// then one finish transaction; the block returns eight digest word
// transactions, word 0 first, last_word set on word 7, and then starts over
// from the initial hash values. An absorb byte that completes a 64-byte
// block holds s_ready low through a load state, 64 rounds on the shared
// round unit (one per cycle), the round unit's registered done flag, and a
// fold state. A finish holds s_ready low through a padding state, then one
// such compression, or two when 56 or more bytes are buffered, then the
// eight output transactions, which follow m_ready. The byte count saturates
// at 2^61-1.
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire s_item_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output m_item_t      m_data
);
    state_t state_reg, state_next;

    logic [31:0]  blk_reg [16];  // block buffer, four bytes per word, big-endian
    logic [5:0]   fill_reg;
    logic [60:0]  len_reg;
    logic [31:0]  chain_reg [8];
    logic         final_reg;   // finish taken: compressions in flight close a message
    logic         second_reg;  // a length-only block still has to follow
    logic [2:0]   widx_reg;

    round_ctl_t   ctl_to, ctl_from;
    logic [511:0] block_bus;
    logic [255:0] chain_bus, vars_bus;
    logic [63:0]  len_bits;
    logic         s_fire, m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;
    assign len_bits = {len_reg, 3'b000};

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            block_bus[511 - 32*i -: 32] = blk_reg[i];
        end
        for (int i = 0; i < 8; i++) begin
            chain_bus[255 - 32*i -: 32] = chain_reg[i];
        end
    end

    sha256_round u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl_in   (ctl_to),
        .ctl_out  (ctl_from),
        .block    (block_bus),
        .chain_in (chain_bus),
        .vars_out (vars_bus)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.opcode == OP_FINISH) begin
                        state_next = ST_PAD;
                    end else if (fill_reg == 6'd63) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_PAD:   state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: if (ctl_from.done) state_next = ST_FOLD;
            ST_FOLD: begin
                if (second_reg) state_next = ST_LOAD;
                else if (final_reg) state_next = ST_EMIT;
                else state_next = ST_IDLE;
            end
            ST_EMIT:  if (m_fire && widx_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        ctl_to.start = (state_reg == ST_LOAD);
        ctl_to.done  = 1'b0;
        m_valid      = (state_reg == ST_EMIT);
        m_data.digest_word = chain_reg[widx_reg];
        m_data.word_index  = widx_reg;
        m_data.last_word   = (widx_reg == 3'd7);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            len_reg    <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            widx_reg   <= '0;
            for (int i = 0; i < 8; i++) chain_reg[i] <= init_hash(3'(i));
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_data.opcode == OP_FINISH) begin
                            final_reg  <= 1'b1;
                            second_reg <= (fill_reg >= 6'd56);
                        end else begin
                            fill_reg <= fill_reg + 6'd1;
                            if (len_reg != LEN_MAX) len_reg <= len_reg + 61'd1;
                        end
                    end
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        chain_reg[i] <= chain_reg[i] + vars_bus[255 - 32*i -: 32];
                    end
                    second_reg <= 1'b0;
                end
                ST_EMIT: begin
                    if (m_fire) begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7) begin
                            final_reg <= 1'b0;
                            fill_reg  <= '0;
                            len_reg   <= '0;
                            for (int i = 0; i < 8; i++) chain_reg[i] <= init_hash(3'(i));
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Block buffer: byte writes, padding, and length fill for the closing block.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.opcode == OP_ABSORB) begin
                        for (int j = 0; j < 16; j++) begin
                            for (int k = 0; k < 4; k++) begin
                                if (6'(4*j + k) == fill_reg) begin
                                    blk_reg[j][31 - 8*k -: 8] <= s_data.msg_byte;
                                end
                            end
                        end
                    end else begin
                        for (int j = 0; j < 16; j++) begin
                            for (int k = 0; k < 4; k++) begin
                                if (6'(4*j + k) == fill_reg) begin
                                    blk_reg[j][31 - 8*k -: 8] <= 8'h80;
                                end else if (6'(4*j + k) > fill_reg) begin
                                    blk_reg[j][31 - 8*k -: 8] <= 8'h00;
                                end
                            end
                        end
                    end
                end
            end
            ST_PAD: begin
                // Place the bit length unless a second block carries it.
                if (!second_reg) begin
                    blk_reg[14] <= len_bits[63:32];
                    blk_reg[15] <= len_bits[31:0];
                end
            end
            ST_FOLD: begin
                if (second_reg) begin
                    for (int j = 0; j < 14; j++) blk_reg[j] <= '0;
                    blk_reg[14] <= len_bits[63:32];
                    blk_reg[15] <= len_bits[31:0];
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/sha256_round.sv =====
// Round unit: one SHA-256 round per cycle with rolling schedule window.
`timescale 1ns / 1ps
`default_nettype none
module sha256_round
    import sha256_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire round_ctl_t  ctl_in,
    output round_ctl_t       ctl_out,
    input  wire logic [511:0] block,
    input  wire logic [255:0] chain_in,
    output logic      [255:0] vars_out
);
    logic [31:0] win_reg [16];
    logic [31:0] v_reg [8];
    logic [5:0]  t_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] w2, w15, s0, s1, w, t1, t2;

    always_comb begin
        w2  = win_reg[4'(t_reg - 6'd2)];
        w15 = win_reg[4'(t_reg - 6'd15)];
        s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        if (t_reg < 6'd16) begin
            w = win_reg[t_reg[3:0]];
        end else begin
            w = s1 + win_reg[4'(t_reg - 6'd7)] + s0 + win_reg[t_reg[3:0]];
        end
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[t_reg] + w;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            t_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl_in.start) begin
                busy_reg <= 1'b1;
                t_reg    <= '0;
            end else if (busy_reg) begin
                t_reg <= t_reg + 6'd1;
                if (t_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.start) begin
            for (int i = 0; i < 16; i++) begin
                win_reg[i] <= block[511 - 32*i -: 32];
            end
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= chain_in[255 - 32*i -: 32];
            end
        end else if (busy_reg) begin
            win_reg[t_reg[3:0]] <= w;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            vars_out[255 - 32*i -: 32] = v_reg[i];
        end
        ctl_out.start = 1'b0;
        ctl_out.done  = done_reg;
    end
endmodule
`default_nettype wire

// ===== rtl/core/sha256_checker.sv =====
// Checker: port-level properties of the hasher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sha256_checker
    import sha256_pkg::*;
(
    input wire logic    aclk,
    input wire logic    aresetn,
    input wire logic    s_valid,
    input wire logic    s_ready,
    input wire s_item_t s_data,
    input wire logic    m_valid,
    input wire logic    m_ready,
    input wire m_item_t m_data
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while digest pending");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_word == (m_data.word_index == 3'd7)))
        else $error("last_word mismatch");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_word) |=>
        (m_valid && m_data.word_index == $past(m_data.word_index) + 3'd1))
        else $error("digest words out of order");

    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.opcode == OP_FINISH) |=> !s_ready)
        else $error("ready after finish");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("output changed while stalled");
endmodule

bind sha256_stream_hasher sha256_checker u_checker (.*);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the streaming SHA-256 hasher: directed and random messages checked per word.
`timescale 1ns / 1ps
module tb_top;
    import sha256_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    s_item_t s_data = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    m_item_t m_data;

    sha256_stream_hasher uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // Predictor state: our own copy of the hash state.
    logic [31:0] hash_state [8];
    logic [7:0]  pend_block [64];
    logic [5:0]  pend_fill;
    logic [60:0] byte_total;
    m_item_t     digest_queue [$];

    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    longint      cycle_count = 0;

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic clear_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
        for (int i = 0; i < 64; i++) pend_block[i] = 8'h00;
        pend_fill = '0;
        byte_total = '0;
    endtask

    task automatic compress_pending();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {pend_block[4*i], pend_block[4*i+1], pend_block[4*i+2], pend_block[4*i+3]};
        for (int t = 16; t < 64; t++) begin
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    // Advance the predictor by one accepted transaction.
    task automatic predict_digest(s_item_t it);
        logic [63:0] bits;
        m_item_t     word;
        if (it.opcode == OP_ABSORB) begin
            pend_block[pend_fill] = it.msg_byte;
            pend_fill = pend_fill + 6'd1;
            if (byte_total != LEN_MAX) byte_total = byte_total + 61'd1;
            if (pend_fill == 6'd0) compress_pending();
        end else begin
            pend_block[pend_fill] = 8'h80;
            for (int i = int'(pend_fill) + 1; i < 64; i++) pend_block[i] = 8'h00;
            if (pend_fill >= 6'd56) begin
                compress_pending();
                for (int i = 0; i < 56; i++) pend_block[i] = 8'h00;
            end
            bits = {byte_total, 3'b000};
            for (int i = 0; i < 8; i++) pend_block[56+i] = bits[63-8*i -: 8];
            compress_pending();
            for (int i = 0; i < 8; i++) begin
                word.digest_word = hash_state[i];
                word.word_index  = 3'(i);
                word.last_word   = (i == 7);
                digest_queue.push_back(word);
            end
            clear_hash();
        end
    endtask

    // Send one transaction; valid stays high until accepted, idles drawn per item.
    // Lower valid only when a gap precedes this item.
    task automatic send_item(logic op, logic [7:0] b);
        s_item_t it;
        it.opcode = op;
        it.msg_byte = b;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_digest(it);
    endtask

    // Hold valid across back-to-back items: lower it only when a gap follows.
    task automatic send_message(int len, bit rand_bytes, logic [7:0] fixed);
        for (int i = 0; i < len; i++)
            send_item(OP_ABSORB, rand_bytes ? 8'($urandom) : fixed);
        send_item(OP_FINISH, 8'($urandom));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // Receiver stalls and result checking.
    always @(posedge aclk) begin
        m_item_t exp_word;
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (digest_queue.size() == 0) begin
                    $display("%0t: unexpected digest word %h", $time, m_data);
                    fail_count++;
                end else begin
                    exp_word = digest_queue.pop_front();
                    if (m_data.digest_word !== exp_word.digest_word) begin
                        $display("%0t: digest_word expected %h actual %h", $time,
                                 exp_word.digest_word, m_data.digest_word);
                        fail_count++;
                    end
                    if (m_data.word_index !== exp_word.word_index) begin
                        $display("%0t: word_index expected %0d actual %0d", $time,
                                 exp_word.word_index, m_data.word_index);
                        fail_count++;
                    end
                    if (m_data.last_word !== exp_word.last_word) begin
                        $display("%0t: last_word expected %b actual %b", $time,
                                 exp_word.last_word, m_data.last_word);
                        fail_count++;
                    end
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Empty message, single bytes at extremes, abc, padding boundaries 55/56/64.
    task automatic test_directed();
        send_message(0, 1'b0, 8'h00);
        send_message(1, 1'b0, 8'hff);
        send_message(1, 1'b0, 8'h00);
        send_item(OP_ABSORB, 8'h61);
        send_item(OP_ABSORB, 8'h62);
        send_item(OP_ABSORB, 8'h63);
        send_item(OP_FINISH, 8'hff);
        send_message(55, 1'b1, 8'h00);
        send_message(56, 1'b1, 8'h00);
        send_message(64, 1'b1, 8'h00);
        drain_results();
    endtask

    // Random messages: mostly short, some crossing block boundaries.
    task automatic test_random(int sidle, int rstall);
        int budget;
        int len;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        budget = 25;
        while (budget > 0) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(80) : $urandom_range(12);
            send_message(len, 1'b1, 8'h00);
            budget -= len + 1;
        end
        drain_results();
    endtask

    initial begin
        clear_hash();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(0, 0);
        test_random(82, 0);
        test_random(0, 82);
        test_random(10, 10);
        if (fail_count == 0 && digest_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
